// ===== hdl/lps_pkg.sv =====
// Shared types and codes for the link pairing session block.
// Used by lps_step, lps_outq and link_pairing_session_fsm; depends on nothing.
package lps_pkg;

    // request commands
    localparam logic [3:0] CMD_CONNECT     = 4'd0;
    localparam logic [3:0] CMD_SIG_CHECK   = 4'd1;
    localparam logic [3:0] CMD_UID_DESCR   = 4'd2;
    localparam logic [3:0] CMD_OTHER_DESCR = 4'd3;
    localparam logic [3:0] CMD_PAIRED      = 4'd4;
    localparam logic [3:0] CMD_UNPAIRED    = 4'd5;
    localparam logic [3:0] CMD_PAIR_REQ    = 4'd6;
    localparam logic [3:0] CMD_LOGON_ACK   = 4'd7;
    localparam logic [3:0] CMD_LOGON       = 4'd8;
    localparam logic [3:0] CMD_LOGON_REJ   = 4'd9;
    localparam logic [3:0] CMD_OTHER_MSG   = 4'd10;
    localparam logic [3:0] CMD_DISCONNECT  = 4'd11;
    localparam logic [3:0] CMD_HOST_LOGON  = 4'd12;
    localparam logic [3:0] CMD_HOST_LOGOFF = 4'd13;

    // messages to send
    localparam logic [3:0] SEND_NONE        = 4'd0;
    localparam logic [3:0] SEND_ST_PAIRED   = 4'd1;
    localparam logic [3:0] SEND_ST_UNPAIRED = 4'd2;
    localparam logic [3:0] SEND_PAIR_REQ    = 4'd3;
    localparam logic [3:0] SEND_LOGON       = 4'd4;
    localparam logic [3:0] SEND_LOGOFF      = 4'd5;
    localparam logic [3:0] SEND_LOGON_REJ   = 4'd6;
    localparam logic [3:0] SEND_FORWARD     = 4'd7;
    localparam logic [3:0] SEND_STARTUP_SET = 4'd8;
    localparam logic [3:0] SEND_CLOSE       = 4'd9;

    // link states
    localparam logic [2:0] ST_STARTUP  = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_UNPAIRED = 3'd2;
    localparam logic [2:0] ST_THEIR_RQ = 3'd3;
    localparam logic [2:0] ST_MY_RQ    = 3'd4;
    localparam logic [2:0] ST_PAIRED   = 3'd5;
    localparam logic [2:0] ST_CONTROL  = 3'd6;

    // host logon return codes
    localparam logic [2:0] HC_STARTED   = 3'd0;
    localparam logic [2:0] HC_ALREADY   = 3'd1;
    localparam logic [2:0] HC_OTHER     = 3'd2;
    localparam logic [2:0] HC_NOT_CONN  = 3'd3;
    localparam logic [2:0] HC_NOT_PAIRD = 3'd4;

    typedef struct packed {
        logic [3:0] command;
        logic       signature_ok;
        logic       uid_trusted;
        logic       user_accepts;
        logic       other_has_control;
        logic [7:0] node_number;
    } item_t;

    typedef struct packed {
        logic [2:0] session;
        logic       connected;
        logic       trust;
        logic       pending;
        logic [7:0] node;
    } sess_t;

    typedef struct packed {
        logic [3:0] send_kind;
        logic [2:0] link_state;
        logic       trusted;
        logic       controlling;
        logic [7:0] assigned_node;
        logic       store_trust;
        logic [2:0] host_code;
        logic       last;
    } res_t;

endpackage

// ===== hdl/lps_step.sv =====
// Next-state and result logic for one request of the link pairing session.
// Purely combinational; depends on lps_pkg.
module lps_step
(
    input  lps_pkg::item_t item,
    input  lps_pkg::sess_t cur,
    output lps_pkg::sess_t nxt,
    output lps_pkg::res_t  res0,
    output lps_pkg::res_t  res1,
    output logic [1:0]     count
);

    function automatic lps_pkg::res_t mk(input logic [3:0] kind, input lps_pkg::sess_t s,
                                         input logic store, input logic [2:0] code);
        lps_pkg::res_t r;
        r.send_kind     = kind;
        r.link_state    = s.session;
        r.trusted       = s.trust;
        r.controlling   = (s.session == lps_pkg::ST_CONTROL);
        r.assigned_node = s.node;
        r.store_trust   = store;
        r.host_code     = code;
        r.last          = 1'b0;
        return r;
    endfunction

    lps_pkg::sess_t nx;
    lps_pkg::res_t  r0;
    lps_pkg::res_t  r1;
    logic [1:0]     n;
    logic           st;
    logic [2:0]     code;

    always_comb
    begin
        nx   = cur;
        n    = 2'd0;
        st   = 1'b0;
        code = lps_pkg::HC_STARTED;
        r0   = mk(lps_pkg::SEND_NONE, cur, 1'b0, lps_pkg::HC_STARTED);
        r1   = r0;

        if (item.command inside {[lps_pkg::CMD_SIG_CHECK:lps_pkg::CMD_OTHER_MSG]})
        begin
            if (!cur.connected)
            begin
                n = 2'd1;
            end
            else if (cur.session == lps_pkg::ST_STARTUP)
            begin
                if (item.command == lps_pkg::CMD_SIG_CHECK && item.signature_ok)
                begin
                    nx.session = lps_pkg::ST_NULL;
                    r0 = mk(lps_pkg::SEND_STARTUP_SET, nx, 1'b0, lps_pkg::HC_STARTED);
                end
                else
                begin
                    nx.session   = lps_pkg::ST_STARTUP;
                    nx.connected = 1'b0;
                    nx.pending   = 1'b0;
                    r0 = mk(lps_pkg::SEND_CLOSE, nx, 1'b0, lps_pkg::HC_STARTED);
                end
                n = 2'd1;
            end
            else
            begin
                case (item.command)
                    lps_pkg::CMD_UID_DESCR:
                    begin
                        nx.pending = 1'b0;
                        nx.trust   = item.uid_trusted;
                        nx.session = item.uid_trusted ? lps_pkg::ST_MY_RQ : lps_pkg::ST_UNPAIRED;
                        r0 = mk(item.uid_trusted ? lps_pkg::SEND_ST_PAIRED
                                                 : lps_pkg::SEND_ST_UNPAIRED,
                                nx, 1'b0, lps_pkg::HC_STARTED);
                        n = 2'd1;
                    end
                    lps_pkg::CMD_PAIRED:
                    begin
                        if (cur.session == lps_pkg::ST_MY_RQ || cur.session == lps_pkg::ST_PAIRED)
                        begin
                            if (cur.session == lps_pkg::ST_MY_RQ)
                            begin
                                nx.session = lps_pkg::ST_PAIRED;
                                st         = !cur.trust;
                                nx.trust   = 1'b1;
                            end
                            if (item.other_has_control)
                            begin
                                nx.pending = 1'b0;
                                r0 = mk(lps_pkg::SEND_LOGOFF, nx, st, lps_pkg::HC_STARTED);
                                n  = 2'd1;
                            end
                            else
                            begin
                                nx.pending = 1'b1;
                                if (st)
                                begin
                                    r0 = mk(lps_pkg::SEND_NONE, nx, 1'b1, lps_pkg::HC_STARTED);
                                    n  = 2'd1;
                                end
                            end
                        end
                    end
                    lps_pkg::CMD_UNPAIRED:
                    begin
                        nx.session = lps_pkg::ST_UNPAIRED;
                        nx.trust   = 1'b0;
                        r0 = mk(lps_pkg::SEND_NONE, nx, cur.trust, lps_pkg::HC_STARTED);
                        n  = 2'd1;
                    end
                    lps_pkg::CMD_PAIR_REQ:
                    begin
                        if (cur.session == lps_pkg::ST_PAIRED)
                        begin
                            r0 = mk(lps_pkg::SEND_ST_PAIRED, nx, 1'b0, lps_pkg::HC_STARTED);
                            nx.pending = !item.other_has_control;
                            // logon itself comes from the trailing logon step
                            if (item.other_has_control)
                            begin
                                r1 = mk(lps_pkg::SEND_LOGOFF, nx, 1'b0, lps_pkg::HC_STARTED);
                                n  = 2'd2;
                            end
                            else
                            begin
                                n = 2'd1;
                            end
                        end
                        else if (cur.session == lps_pkg::ST_MY_RQ)
                        begin
                            r0 = mk(lps_pkg::SEND_ST_PAIRED, nx, 1'b0, lps_pkg::HC_STARTED);
                            n  = 2'd1;
                        end
                        else if (cur.session == lps_pkg::ST_UNPAIRED)
                        begin
                            nx.session = lps_pkg::ST_THEIR_RQ;
                            r0 = mk(lps_pkg::SEND_PAIR_REQ, nx, 1'b0, lps_pkg::HC_STARTED);
                            nx.session = item.user_accepts ? lps_pkg::ST_MY_RQ
                                                           : lps_pkg::ST_UNPAIRED;
                            r1 = mk(item.user_accepts ? lps_pkg::SEND_ST_PAIRED
                                                      : lps_pkg::SEND_ST_UNPAIRED,
                                    nx, 1'b0, lps_pkg::HC_STARTED);
                            n  = 2'd2;
                        end
                    end
                    default:
                    begin
                        if (cur.session == lps_pkg::ST_PAIRED)
                        begin
                            if (item.command == lps_pkg::CMD_LOGON_ACK)
                            begin
                                nx.node    = item.node_number;
                                nx.pending = 1'b0;
                                nx.session = lps_pkg::ST_CONTROL;
                            end
                            else if (item.command == lps_pkg::CMD_LOGON)
                            begin
                                r0 = mk(lps_pkg::SEND_LOGON_REJ, nx, 1'b0, lps_pkg::HC_STARTED);
                                n  = 2'd1;
                            end
                            else if (item.command == lps_pkg::CMD_LOGON_REJ)
                            begin
                                nx.pending = 1'b0;
                            end
                        end
                        else if (cur.session == lps_pkg::ST_CONTROL)
                        begin
                            if (item.command == lps_pkg::CMD_LOGON_REJ)
                            begin
                                nx.pending = 1'b0;
                                nx.session = lps_pkg::ST_PAIRED;
                            end
                            else if (item.command != lps_pkg::CMD_OTHER_DESCR)
                            begin
                                r0 = mk(lps_pkg::SEND_FORWARD, nx, 1'b0, lps_pkg::HC_STARTED);
                                n  = 2'd1;
                            end
                        end
                    end
                endcase

                // paired with a logon owed: append it if there is room
                if (nx.session == lps_pkg::ST_PAIRED && nx.pending && n != 2'd2)
                begin
                    if (n == 2'd0)
                        r0 = mk(lps_pkg::SEND_LOGON, nx, 1'b0, lps_pkg::HC_STARTED);
                    else
                        r1 = mk(lps_pkg::SEND_LOGON, nx, 1'b0, lps_pkg::HC_STARTED);
                    n = n + 2'd1;
                end
                if (n == 2'd0)
                begin
                    r0 = mk(lps_pkg::SEND_NONE, nx, 1'b0, lps_pkg::HC_STARTED);
                    n  = 2'd1;
                end
            end
        end
        else
        begin
            n = 2'd1;
            case (item.command)
                lps_pkg::CMD_CONNECT:
                begin
                    nx.session   = lps_pkg::ST_STARTUP;
                    nx.pending   = 1'b0;
                    nx.connected = 1'b1;
                    r0 = mk(lps_pkg::SEND_NONE, nx, 1'b0, lps_pkg::HC_STARTED);
                end
                lps_pkg::CMD_DISCONNECT:
                begin
                    nx.session   = lps_pkg::ST_STARTUP;
                    nx.connected = 1'b0;
                    nx.pending   = 1'b0;
                    r0 = mk(cur.connected ? lps_pkg::SEND_CLOSE : lps_pkg::SEND_NONE,
                            nx, 1'b0, lps_pkg::HC_STARTED);
                end
                lps_pkg::CMD_HOST_LOGON:
                begin
                    if (cur.session == lps_pkg::ST_CONTROL)
                        code = lps_pkg::HC_ALREADY;
                    else if (item.other_has_control)
                        code = lps_pkg::HC_OTHER;
                    else if (cur.session != lps_pkg::ST_PAIRED)
                        code = lps_pkg::HC_NOT_PAIRD;
                    else if (!cur.connected)
                        code = lps_pkg::HC_NOT_CONN;
                    else
                        code = lps_pkg::HC_STARTED;
                    if (code == lps_pkg::HC_STARTED)
                    begin
                        nx.pending = 1'b1;
                        r0 = mk(lps_pkg::SEND_LOGON, nx, 1'b0, lps_pkg::HC_STARTED);
                    end
                    else
                    begin
                        r0 = mk(lps_pkg::SEND_NONE, nx, 1'b0, code);
                    end
                end
                lps_pkg::CMD_HOST_LOGOFF:
                begin
                    if (cur.session == lps_pkg::ST_CONTROL)
                    begin
                        nx.pending = 1'b0;
                        nx.session = lps_pkg::ST_PAIRED;
                        r0 = mk(lps_pkg::SEND_LOGOFF, nx, 1'b0, lps_pkg::HC_STARTED);
                    end
                end
                default:
                begin
                    r0 = mk(lps_pkg::SEND_NONE, nx, 1'b0, lps_pkg::HC_STARTED);
                end
            endcase
        end

        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    assign nxt   = nx;
    assign res0  = r0;
    assign res1  = r1;
    assign count = n;

endmodule

// ===== hdl/lps_outq.sv =====
// Two-entry result buffer: takes one or two results at once, drains one a cycle while out_ready is high.
// Depends on lps_pkg.
module lps_outq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [1:0]    load_cnt,
    input  lps_pkg::res_t load0,
    input  lps_pkg::res_t load1,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output lps_pkg::res_t head
);

    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    lps_pkg::res_t e0_reg;
    lps_pkg::res_t e0_next;
    lps_pkg::res_t e1_reg;
    lps_pkg::res_t e1_next;
    logic          pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // room for a whole pair once the current head leaves
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = e0_reg;

    always_comb
    begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        if (load)
        begin
            count_next = load_cnt;
            e0_next    = load0;
            e1_next    = load1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            e0_next    = e1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

// ===== hdl/link_pairing_session_fsm.sv =====
// Link pairing session machine: one request in, one or two results out.
// The request is registered first, then its results are loaded into the result buffer once it has room.
// Throughput: one request a cycle while out_ready is high and each request yields one result;
// a request that yields two holds up later requests until the first of the pair leaves.
// Reset (async, active low): startup, disconnected, untrusted, no logon owed,
// node 0, input and result buffers empty. Depends on lps_pkg, lps_step, lps_outq.
module link_pairing_session_fsm
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] command,
    input  logic       signature_ok,
    input  logic       uid_trusted,
    input  logic       user_accepts,
    input  logic       other_has_control,
    input  logic [7:0] node_number,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] send_kind,
    output logic [2:0] link_state,
    output logic       trusted,
    output logic       controlling,
    output logic [7:0] assigned_node,
    output logic       store_trust,
    output logic [2:0] host_code,
    output logic       last
);

    logic           in_valid_reg;
    logic           in_valid_next;
    lps_pkg::item_t in_reg;
    lps_pkg::sess_t sess_reg;
    lps_pkg::sess_t sess_next;
    lps_pkg::sess_t step_nxt;
    lps_pkg::res_t  res0;
    lps_pkg::res_t  res1;
    lps_pkg::res_t  head;
    logic [1:0]     res_cnt;
    logic           can_load;
    logic           commit;
    logic           take;

    assign commit   = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || can_load;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (commit)
            in_valid_next = 1'b0;
        sess_next = commit ? step_nxt : sess_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sess_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sess_reg     <= sess_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.command           <= command;
            in_reg.signature_ok      <= signature_ok;
            in_reg.uid_trusted       <= uid_trusted;
            in_reg.user_accepts      <= user_accepts;
            in_reg.other_has_control <= other_has_control;
            in_reg.node_number       <= node_number;
        end
    end

    lps_step u_step
    (
        .item  (in_reg),
        .cur   (sess_reg),
        .nxt   (step_nxt),
        .res0  (res0),
        .res1  (res1),
        .count (res_cnt)
    );

    lps_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (commit),
        .load_cnt  (res_cnt),
        .load0     (res0),
        .load1     (res1),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign send_kind     = head.send_kind;
    assign link_state    = head.link_state;
    assign trusted       = head.trusted;
    assign controlling   = head.controlling;
    assign assigned_node = head.assigned_node;
    assign store_trust   = head.store_trust;
    assign host_code     = head.host_code;
    assign last          = head.last;

    // a dropped link always sits in startup with no logon owed
    a_disconnected_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !sess_reg.connected |-> (sess_reg.session == lps_pkg::ST_STARTUP && !sess_reg.pending))
        else $error("disconnected link not idle");

    a_commit_shows : assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("committed request produced no result");

    a_ctrl_flag : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (controlling == (link_state == lps_pkg::ST_CONTROL)))
        else $error("control flag disagrees with link state");

    a_step_count : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (res_cnt == 2'd1 || res_cnt == 2'd2))
        else $error("request gives no result or too many");

endmodule

// ===== verif/lps_session_checker.sv =====
`timescale 1ns / 1ps
// Session checker for link_pairing_session_fsm: predicts the results of every
// request taken on the input channel and compares them with the result channel.
// Depends on lps_pkg.
module lps_session_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [3:0] command,
    input  logic       signature_ok,
    input  logic       uid_trusted,
    input  logic       user_accepts,
    input  logic       other_has_control,
    input  logic [7:0] node_number,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] send_kind,
    input  logic [2:0] link_state,
    input  logic       trusted,
    input  logic       controlling,
    input  logic [7:0] assigned_node,
    input  logic       store_trust,
    input  logic [2:0] host_code,
    input  logic       last,
    output int         mismatches,
    output int         outstanding,
    output int         results_checked
);

    localparam logic [2:0] NO_CODE = 3'd0;

    // predicted session state
    logic [2:0] sess;
    logic       link_up;
    logic       trust;
    logic       logon_owed;
    logic [7:0] node_q;

    lps_pkg::res_t ev_out [0:1];
    int            ev_n;
    lps_pkg::res_t expected_q [$];
    int            fault_count;
    int            checked_count;

    function automatic void emit(logic [3:0] kind, logic store, logic [2:0] code);
        lps_pkg::res_t r;
        r.send_kind     = kind;
        r.link_state    = sess;
        r.trusted       = trust;
        r.controlling   = (sess == lps_pkg::ST_CONTROL);
        r.assigned_node = node_q;
        r.store_trust   = store;
        r.host_code     = code;
        r.last          = 1'b0;
        if (ev_n < 2)
            ev_out[ev_n[0]] = r;
        ev_n++;
    endfunction

    // logon is owed unless another connection holds control, which earns a logoff
    function automatic void claim_logon(logic other);
        if (!other)
            logon_owed = 1'b1;
        else
        begin
            logon_owed = 1'b0;
            emit(lps_pkg::SEND_LOGOFF, 1'b0, NO_CODE);
        end
    endfunction

    task automatic predict_event(input lps_pkg::item_t rq);
        logic       trust_set;
        logic       was_up;
        logic [2:0] code;
        ev_n = 0;
        trust_set = 1'b0;
        if (rq.command >= lps_pkg::CMD_SIG_CHECK && rq.command <= lps_pkg::CMD_OTHER_MSG)
        begin
            if (!link_up)
                emit(lps_pkg::SEND_NONE, 1'b0, NO_CODE);
            else if (sess == lps_pkg::ST_STARTUP)
            begin
                if (rq.command == lps_pkg::CMD_SIG_CHECK && rq.signature_ok)
                begin
                    sess = lps_pkg::ST_NULL;
                    emit(lps_pkg::SEND_STARTUP_SET, 1'b0, NO_CODE);
                end
                else
                begin
                    sess = lps_pkg::ST_STARTUP;
                    link_up = 1'b0;
                    logon_owed = 1'b0;
                    emit(lps_pkg::SEND_CLOSE, 1'b0, NO_CODE);
                end
            end
            else
            begin
                case (rq.command)
                    lps_pkg::CMD_UID_DESCR:
                    begin
                        logon_owed = 1'b0;
                        trust = rq.uid_trusted;
                        if (rq.uid_trusted)
                        begin
                            sess = lps_pkg::ST_MY_RQ;
                            emit(lps_pkg::SEND_ST_PAIRED, 1'b0, NO_CODE);
                        end
                        else
                        begin
                            sess = lps_pkg::ST_UNPAIRED;
                            emit(lps_pkg::SEND_ST_UNPAIRED, 1'b0, NO_CODE);
                        end
                    end
                    lps_pkg::CMD_PAIRED:
                    begin
                        if (sess == lps_pkg::ST_MY_RQ)
                        begin
                            sess = lps_pkg::ST_PAIRED;
                            trust_set = !trust;
                            trust = 1'b1;
                            claim_logon(rq.other_has_control);
                            // trust strobe rides on the first result of the request
                            if (trust_set)
                            begin
                                if (ev_n == 0)
                                    emit(lps_pkg::SEND_NONE, 1'b1, NO_CODE);
                                else
                                    ev_out[0].store_trust = 1'b1;
                            end
                        end
                        else if (sess == lps_pkg::ST_PAIRED)
                            claim_logon(rq.other_has_control);
                    end
                    lps_pkg::CMD_UNPAIRED:
                    begin
                        sess = lps_pkg::ST_UNPAIRED;
                        trust_set = trust;
                        trust = 1'b0;
                        emit(lps_pkg::SEND_NONE, trust_set, NO_CODE);
                    end
                    lps_pkg::CMD_PAIR_REQ:
                    begin
                        if (sess == lps_pkg::ST_PAIRED)
                        begin
                            emit(lps_pkg::SEND_ST_PAIRED, 1'b0, NO_CODE);
                            claim_logon(rq.other_has_control);
                        end
                        else if (sess == lps_pkg::ST_MY_RQ)
                            emit(lps_pkg::SEND_ST_PAIRED, 1'b0, NO_CODE);
                        else if (sess == lps_pkg::ST_UNPAIRED)
                        begin
                            sess = lps_pkg::ST_THEIR_RQ;
                            emit(lps_pkg::SEND_PAIR_REQ, 1'b0, NO_CODE);
                            if (rq.user_accepts)
                            begin
                                sess = lps_pkg::ST_MY_RQ;
                                emit(lps_pkg::SEND_ST_PAIRED, 1'b0, NO_CODE);
                            end
                            else
                            begin
                                sess = lps_pkg::ST_UNPAIRED;
                                emit(lps_pkg::SEND_ST_UNPAIRED, 1'b0, NO_CODE);
                            end
                        end
                    end
                    default:
                    begin
                        if (sess == lps_pkg::ST_PAIRED)
                        begin
                            if (rq.command == lps_pkg::CMD_LOGON_ACK)
                            begin
                                node_q = rq.node_number;
                                logon_owed = 1'b0;
                                sess = lps_pkg::ST_CONTROL;
                            end
                            else if (rq.command == lps_pkg::CMD_LOGON)
                                emit(lps_pkg::SEND_LOGON_REJ, 1'b0, NO_CODE);
                            else if (rq.command == lps_pkg::CMD_LOGON_REJ)
                                logon_owed = 1'b0;
                        end
                        else if (sess == lps_pkg::ST_CONTROL)
                        begin
                            if (rq.command == lps_pkg::CMD_LOGON_REJ)
                            begin
                                logon_owed = 1'b0;
                                sess = lps_pkg::ST_PAIRED;
                            end
                            else if (rq.command != lps_pkg::CMD_OTHER_DESCR)
                                emit(lps_pkg::SEND_FORWARD, 1'b0, NO_CODE);
                        end
                    end
                endcase
                if (sess == lps_pkg::ST_PAIRED && logon_owed && ev_n < 2)
                    emit(lps_pkg::SEND_LOGON, 1'b0, NO_CODE);
                if (ev_n == 0)
                    emit(lps_pkg::SEND_NONE, 1'b0, NO_CODE);
            end
        end
        else if (rq.command == lps_pkg::CMD_CONNECT)
        begin
            sess = lps_pkg::ST_STARTUP;
            logon_owed = 1'b0;
            link_up = 1'b1;
            emit(lps_pkg::SEND_NONE, 1'b0, NO_CODE);
        end
        else if (rq.command == lps_pkg::CMD_DISCONNECT)
        begin
            was_up = link_up;
            sess = lps_pkg::ST_STARTUP;
            link_up = 1'b0;
            logon_owed = 1'b0;
            emit(was_up ? lps_pkg::SEND_CLOSE : lps_pkg::SEND_NONE, 1'b0, NO_CODE);
        end
        else if (rq.command == lps_pkg::CMD_HOST_LOGON)
        begin
            if (sess == lps_pkg::ST_CONTROL)
                code = lps_pkg::HC_ALREADY;
            else if (rq.other_has_control)
                code = lps_pkg::HC_OTHER;
            else if (sess != lps_pkg::ST_PAIRED)
                code = lps_pkg::HC_NOT_PAIRD;
            else if (!link_up)
                code = lps_pkg::HC_NOT_CONN;
            else
                code = lps_pkg::HC_STARTED;
            if (code == lps_pkg::HC_STARTED)
            begin
                logon_owed = 1'b1;
                emit(lps_pkg::SEND_LOGON, 1'b0, NO_CODE);
            end
            else
                emit(lps_pkg::SEND_NONE, 1'b0, code);
        end
        else if (rq.command == lps_pkg::CMD_HOST_LOGOFF)
        begin
            if (sess == lps_pkg::ST_CONTROL)
            begin
                logon_owed = 1'b0;
                sess = lps_pkg::ST_PAIRED;
                emit(lps_pkg::SEND_LOGOFF, 1'b0, NO_CODE);
            end
            else
                emit(lps_pkg::SEND_NONE, 1'b0, NO_CODE);
        end
        else
            emit(lps_pkg::SEND_NONE, 1'b0, NO_CODE);

        for (int i = 0; i < ev_n && i < 2; i++)
        begin
            lps_pkg::res_t r;
            r = ev_out[i[0]];
            r.last = (i == ev_n - 1);
            expected_q.push_back(r);
        end
    endtask

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess = lps_pkg::ST_STARTUP;
            link_up = 1'b0;
            trust = 1'b0;
            logon_owed = 1'b0;
            node_q = 8'd0;
            expected_q.delete();
            fault_count = 0;
            checked_count = 0;
            mismatches <= 0;
            outstanding <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                lps_pkg::item_t rq;
                rq.command           = command;
                rq.signature_ok      = signature_ok;
                rq.uid_trusted       = uid_trusted;
                rq.user_accepts      = user_accepts;
                rq.other_has_control = other_has_control;
                rq.node_number       = node_number;
                predict_event(rq);
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, send_kind %0d link_state %0d",
                             $time, send_kind, link_state);
                    fault_count++;
                end
                else
                begin
                    lps_pkg::res_t want;
                    want = expected_q.pop_front();
                    check_field("send_kind", 8'(want.send_kind), 8'(send_kind));
                    check_field("link_state", 8'(want.link_state), 8'(link_state));
                    check_field("trusted", 8'(want.trusted), 8'(trusted));
                    check_field("controlling", 8'(want.controlling), 8'(controlling));
                    check_field("assigned_node", want.assigned_node, assigned_node);
                    check_field("store_trust", 8'(want.store_trust), 8'(store_trust));
                    check_field("host_code", 8'(want.host_code), 8'(host_code));
                    check_field("last", 8'(want.last), 8'(last));
                    checked_count++;
                end
            end
            mismatches <= fault_count;
            outstanding <= expected_q.size();
            results_checked <= checked_count;
        end
    end

endmodule

// ===== verif/tb_link_pairing_session_fsm.sv =====
`timescale 1ns / 1ps
// Testbench top for link_pairing_session_fsm: directed and random session
// requests with random idling on both channels; lps_session_checker judges.
// Depends on lps_pkg, link_pairing_session_fsm and lps_session_checker.
module tb_link_pairing_session_fsm;

    localparam int         REQUEST_TARGET = 1450;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         IDLE_PCT       = 37;
    localparam logic [3:0] CMD_UNUSED     = 4'd15;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] command;
    logic       signature_ok;
    logic       uid_trusted;
    logic       user_accepts;
    logic       other_has_control;
    logic [7:0] node_number;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] send_kind;
    logic [2:0] link_state;
    logic       trusted;
    logic       controlling;
    logic [7:0] assigned_node;
    logic       store_trust;
    logic [2:0] host_code;
    logic       last;

    int mismatches;
    int outstanding;
    int results_checked;
    int requests_sent = 0;
    int sessions_run = 0;
    int cycle_count = 0;
    logic quiet = 1'b0;
    logic [3:0] session_menu [16];

    link_pairing_session_fsm dut (.*);

    lps_session_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_link_pairing_session_fsm: FAIL");
            $finish;
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic lps_pkg::item_t make_request(logic [3:0] cmd, logic sig, logic uid,
                                                    logic acc, logic oth, logic [7:0] node);
        lps_pkg::item_t rq;
        rq.command           = cmd;
        rq.signature_ok      = sig;
        rq.uid_trusted       = uid;
        rq.user_accepts      = acc;
        rq.other_has_control = oth;
        rq.node_number       = node;
        return rq;
    endfunction

    // mostly good signatures, control mostly free so logons go through
    function automatic lps_pkg::item_t session_request(logic [3:0] cmd);
        return make_request(cmd, $urandom_range(9) != 0, 1'($urandom_range(1)),
                            1'($urandom_range(1)), $urandom_range(3) == 0,
                            8'($urandom_range(255)));
    endfunction

    function automatic lps_pkg::item_t random_request();
        return make_request(4'($urandom_range(15)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 8'($urandom_range(255)));
    endfunction

    task automatic send_request(input lps_pkg::item_t rq);
        quiet = (requests_sent >= 500 && requests_sent < 760);
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid          <= 1'b1;
        command           <= rq.command;
        signature_ok      <= rq.signature_ok;
        uid_trusted       <= rq.uid_trusted;
        user_accepts      <= rq.user_accepts;
        other_has_control <= rq.other_has_control;
        node_number       <= rq.node_number;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // connect, then usually a well-formed opening and random traffic inside the session
    task automatic run_session();
        int steps;
        sessions_run++;
        send_request(session_request(lps_pkg::CMD_CONNECT));
        if ($urandom_range(7) == 0)
            send_request(random_request());
        else
        begin
            send_request(session_request(lps_pkg::CMD_SIG_CHECK));
            send_request(session_request(lps_pkg::CMD_UID_DESCR));
            if ($urandom_range(1) == 1)
                send_request(session_request(lps_pkg::CMD_PAIR_REQ));
            send_request(session_request(lps_pkg::CMD_PAIRED));
            steps = int'($urandom_range(14, 4));
            repeat (steps)
                send_request(session_request(session_menu[4'($urandom_range(15))]));
        end
        if ($urandom_range(4) != 0)
            send_request(session_request(lps_pkg::CMD_DISCONNECT));
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        command           <= lps_pkg::CMD_CONNECT;
        signature_ok      <= 1'b0;
        uid_trusted       <= 1'b0;
        user_accepts      <= 1'b0;
        other_has_control <= 1'b0;
        node_number       <= 8'd0;
        session_menu = '{lps_pkg::CMD_LOGON_ACK, lps_pkg::CMD_LOGON_ACK,
                         lps_pkg::CMD_HOST_LOGON, lps_pkg::CMD_HOST_LOGON,
                         lps_pkg::CMD_LOGON, lps_pkg::CMD_LOGON_REJ,
                         lps_pkg::CMD_OTHER_MSG, lps_pkg::CMD_OTHER_MSG,
                         lps_pkg::CMD_OTHER_DESCR, lps_pkg::CMD_HOST_LOGOFF,
                         lps_pkg::CMD_HOST_LOGOFF, lps_pkg::CMD_PAIR_REQ,
                         lps_pkg::CMD_PAIRED, lps_pkg::CMD_UNPAIRED,
                         lps_pkg::CMD_SIG_CHECK, lps_pkg::CMD_UID_DESCR};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not connected: messages ignored, unknown command, idle disconnect, host logon refused
        send_request(make_request(lps_pkg::CMD_SIG_CHECK, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_request(make_request(CMD_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_request(make_request(lps_pkg::CMD_DISCONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_HOST_LOGON, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // startup failures, reconnect while connected
        send_request(make_request(lps_pkg::CMD_CONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_PAIR_REQ, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_CONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_CONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_SIG_CHECK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_CONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_SIG_CHECK, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_SIG_CHECK, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        // pairing by user request, then logon into control
        send_request(make_request(lps_pkg::CMD_UID_DESCR, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_PAIR_REQ, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_PAIR_REQ, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_PAIRED, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_LOGON_ACK, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_request(make_request(lps_pkg::CMD_HOST_LOGON, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // unpair while in control drops control
        send_request(make_request(lps_pkg::CMD_UNPAIRED, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // trusted UID, foreign control forces a logoff
        send_request(make_request(lps_pkg::CMD_UID_DESCR, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_PAIRED, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
        send_request(make_request(lps_pkg::CMD_HOST_LOGON, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
        send_request(make_request(lps_pkg::CMD_HOST_LOGON, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_LOGON_ACK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_HOST_LOGOFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(lps_pkg::CMD_DISCONNECT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));

        while (requests_sent < REQUEST_TARGET)
        begin
            if ($urandom_range(9) == 0)
                send_request(random_request());
            else
                run_session();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d requests (directed set plus %0d random sessions and noise),",
                 requests_sent, sessions_run);
        $display("checked %0d results with %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_link_pairing_session_fsm: PASS");
        else
            $display("tb_link_pairing_session_fsm: FAIL");
        $finish;
    end

endmodule
